FILE: sv/tti_pkg.sv
package tti_pkg;

  localparam int RES_W = 16;
  localparam int TEMP_W = 7;
  localparam int STAT_W = 2;

  // table held in logic, entries in use clamped to what is stored
  localparam int STORED_ENTRIES = 25;
  localparam int TABLE_ENTRIES = 25;
  localparam int ENTRIES = (TABLE_ENTRIES < 2) ? 2 :
                           ((TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES : TABLE_ENTRIES);
  localparam int IDX_W = $clog2(STORED_ENTRIES);
  localparam int DEG_STEP = 5;

  // divider: quotient never exceeds one degree step, so three bits suffice
  localparam int QUO_W = 3;
  localparam int CNT_W = 2;
  localparam int NUM_W = RES_W + QUO_W;

  localparam logic [STAT_W-1:0] STATUS_IN_RANGE = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_COLD = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_HOT = 2'd2;

  localparam logic [TEMP_W-1:0] HOT_TEMP = TEMP_W'((ENTRIES - 1) * DEG_STEP + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(ENTRIES - 2);

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_ADVANCE = 4'd2,
    OP_PREP    = 4'd3,
    OP_DIV     = 4'd4,
    OP_FINISH  = 4'd5,
    OP_COLD    = 4'd6,
    OP_HOT     = 4'd7
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_INPUT  = 3'd2,
    COND_COLD      = 3'd3,
    COND_HOT       = 3'd4,
    COND_NOT_FOUND = 3'd5,
    COND_DIV_MORE  = 3'd6
  } cond_t;

  localparam int PROG_LEN = 9;
  localparam int PC_W = $clog2(PROG_LEN);

  localparam logic [PC_W-1:0] PC_WAIT = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SEARCH = PC_W'(3);
  localparam logic [PC_W-1:0] PC_DIV = PC_W'(5);
  localparam logic [PC_W-1:0] PC_COLD = PC_W'(7);
  localparam logic [PC_W-1:0] PC_HOT = PC_W'(8);

  typedef struct packed {
    op_t op;
    cond_t cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic cold;
    logic hot;
    logic not_found;
    logic div_more;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    op_t op;
    logic go;
  } ctrl_t;

  // falls through to pc + 1 when the condition is false
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_W'(0): w = '{OP_LOAD, COND_NO_INPUT, PC_WAIT};
      PC_W'(1): w = '{OP_NONE, COND_COLD, PC_COLD};
      PC_W'(2): w = '{OP_NONE, COND_HOT, PC_HOT};
      PC_W'(3): w = '{OP_ADVANCE, COND_NOT_FOUND, PC_SEARCH};
      PC_W'(4): w = '{OP_PREP, COND_NEVER, PC_WAIT};
      PC_W'(5): w = '{OP_DIV, COND_DIV_MORE, PC_DIV};
      PC_W'(6): w = '{OP_FINISH, COND_ALWAYS, PC_WAIT};
      PC_W'(7): w = '{OP_COLD, COND_ALWAYS, PC_WAIT};
      PC_W'(8): w = '{OP_HOT, COND_ALWAYS, PC_WAIT};
      default: w = '{OP_NONE, COND_ALWAYS, PC_WAIT};
    endcase
    return w;
  endfunction

  // falling resistance table, one entry every 5 degrees from 0
  function automatic logic [RES_W-1:0] res_lookup(input logic [IDX_W-1:0] i);
    logic [RES_W-1:0] v;
    case (i)
      5'd0: v = 16'd5743;
      5'd1: v = 16'd4627;
      5'd2: v = 16'd3749;
      5'd3: v = 16'd3053;
      5'd4: v = 16'd2499;
      5'd5: v = 16'd2056;
      5'd6: v = 16'd1700;
      5'd7: v = 16'd1412;
      5'd8: v = 16'd1178;
      5'd9: v = 16'd987;
      5'd10: v = 16'd830;
      5'd11: v = 16'd701;
      5'd12: v = 16'd595;
      5'd13: v = 16'd507;
      5'd14: v = 16'd433;
      5'd15: v = 16'd371;
      5'd16: v = 16'd319;
      5'd17: v = 16'd276;
      5'd18: v = 16'd239;
      5'd19: v = 16'd208;
      5'd20: v = 16'd181;
      5'd21: v = 16'd158;
      5'd22: v = 16'd139;
      5'd23: v = 16'd122;
      5'd24: v = 16'd108;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/tti_sequencer.sv
module tti_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  tti_pkg::flags_t flags,
  output tti_pkg::ctrl_t  ctrl
);
  import tti_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t word;
  logic taken;
  logic stall;

  assign word = ucode_rom(pc);

  always_comb begin
    case (word.cond)
      COND_NEVER: taken = 1'b0;
      COND_ALWAYS: taken = 1'b1;
      COND_NO_INPUT: taken = !flags.in_valid;
      COND_COLD: taken = flags.cold;
      COND_HOT: taken = flags.hot;
      COND_NOT_FOUND: taken = flags.not_found;
      COND_DIV_MORE: taken = flags.div_more;
      default: taken = 1'b0;
    endcase
  end

  // result-writing steps hold while the output register is still full
  assign stall = flags.out_busy &&
                 (word.op == OP_FINISH || word.op == OP_COLD || word.op == OP_HOT);

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op = word.op;
  assign ctrl.go = !stall;

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc < PC_W'(PROG_LEN))
    else $error("step counter outside program");

  a_stall_holds_pc: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(pc))
    else $error("step counter moved during a stall");

  a_idle_waits: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_WAIT && !flags.in_valid) |=> (pc == PC_WAIT))
    else $error("step counter left the wait step with nothing offered");

endmodule

FILE: sv/thermistor_table_interpolator.sv
// Thermistor table interpolator: takes one resistance in ohms and returns a
// temperature in whole degrees Celsius, truncated, from linear interpolation
// over a falling 25-entry table spaced every 5 degrees (0 to 120 degrees).
// Resistances above the first entry give 0 with range_status 1 (colder than
// the table); below the last entry give 121 with range_status 2 (hotter).
// An exact match on an entry uses the first segment that bounds it.
// A small microprogram walks the table one segment per cycle, then runs a
// three-step restoring divide: a transaction in range passes through an
// accept step, two range checks, 1 to 24 search steps (set by the segment
// search), a setup step, three divide steps and a write-back step. Colder or
// hotter inputs leave after the range checks for their own write-back step.
// Every write-back step waits while the output register holds an untaken result.
// One item is in flight at a time; the output register lets the next
// transaction be accepted while a result still waits to be taken.
module thermistor_table_interpolator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tti_pkg::RES_W-1:0]   resistance_ohms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tti_pkg::TEMP_W-1:0]  temperature_deg,
  output logic [tti_pkg::STAT_W-1:0]  range_status
);
  import tti_pkg::*;

  flags_t flags;
  ctrl_t ctrl;

  // working registers
  logic [RES_W-1:0] res;
  logic [IDX_W-1:0] idx;
  logic [NUM_W-1:0] num;
  logic [RES_W-1:0] den;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;

  logic [RES_W-1:0] r1;
  logic [RES_W-1:0] r2;
  logic [RES_W-1:0] diff;
  logic [NUM_W-1:0] den_sh;
  logic             sub_ok;
  logic [7:0]       t1;
  logic [7:0]       temp_sum;
  logic             wr_out;

  tti_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // segment endpoints for the current index
  assign r1 = res_lookup(idx);
  assign r2 = res_lookup(idx + IDX_W'(1));
  assign diff = r1 - res;

  // divisor aligned to the current quotient bit
  assign den_sh = NUM_W'(den) << cnt;
  assign sub_ok = (num >= den_sh);

  // segment base temperature is idx * 5
  assign t1 = {1'b0, idx, 2'b00} + {3'b000, idx};
  assign temp_sum = t1 + ((den == '0) ? 8'd0 : {5'b00000, quo});

  assign flags.in_valid = in_valid;
  assign flags.cold = (res > res_lookup(IDX_W'(0)));
  assign flags.hot = (res < res_lookup(LAST_IDX));
  assign flags.not_found = (res < r2);
  assign flags.div_more = (cnt != '0);
  assign flags.out_busy = out_valid && !out_ready;

  assign in_ready = (ctrl.op == OP_LOAD);

  assign wr_out = ctrl.go &&
                  (ctrl.op == OP_FINISH || ctrl.op == OP_COLD || ctrl.op == OP_HOT);

  // datapath driven by the current control word
  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      case (ctrl.op)
        OP_LOAD: begin
          if (in_valid) begin
            res <= resistance_ohms;
            idx <= '0;
          end
        end
        OP_ADVANCE: begin
          if (flags.not_found) begin
            idx <= idx + IDX_W'(1);
          end
        end
        OP_PREP: begin
          // (r1 - r) * 5 as a shift and add
          num <= (NUM_W'(diff) << 2) + NUM_W'(diff);
          den <= r1 - r2;
          quo <= '0;
          cnt <= CNT_W'(QUO_W - 1);
        end
        OP_DIV: begin
          if (sub_ok) begin
            num <= num - den_sh;
            quo[cnt] <= 1'b1;
          end
          cnt <= cnt - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_out) begin
      case (ctrl.op)
        OP_COLD: begin
          temperature_deg <= '0;
          range_status <= STATUS_COLD;
        end
        OP_HOT: begin
          temperature_deg <= HOT_TEMP;
          range_status <= STATUS_HOT;
        end
        default: begin
          temperature_deg <= temp_sum[TEMP_W-1:0];
          range_status <= STATUS_IN_RANGE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    wr_out |-> !(out_valid && !out_ready))
    else $error("result written over one not yet taken");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_PREP) |-> (idx <= LAST_SEG))
    else $error("segment search ran past the last segment");

endmodule
